>>> src/dem_pkg.sv
`default_nettype none
package dem_pkg;

  // Metric codes, same encoding as the mode register.
  localparam logic [2:0] MODE_RMSE   = 3'd0;
  localparam logic [2:0] MODE_MAAPE  = 3'd1;
  localparam logic [2:0] MODE_MAPE   = 3'd2;
  localparam logic [2:0] MODE_PCT    = 3'd3;
  localparam logic [2:0] MODE_ABS    = 3'd4;
  localparam logic [2:0] MODE_RFAC   = 3'd5;
  localparam logic [2:0] MODE_EUCL   = 3'd6;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam int unsigned MAX_POINTS_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam logic [63:0] SAT63       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;

  // Iterative unit operations.
  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  // One classified pair as it travels from the front to the back.
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] dif;
    logic [31:0] mag;
    logic        fin;
  } dem_item_t;

  typedef struct packed {
    logic         start;
    logic         op;
    logic [127:0] num;
    logic [63:0]  den;
  } dem_req_t;

  typedef struct packed {
    logic        done;
    logic        over;
    logic [63:0] res;
  } dem_rsp_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [30:0] atan_tab(input logic [4:0] i);
    logic [30:0] r;
    case (i)
      5'd0:  r = 31'd843314856;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043836;
      5'd3:  r = 31'd133525158;
      5'd4:  r = 31'd67021686;
      5'd5:  r = 31'd33543515;
      5'd6:  r = 31'd16775850;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194282;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048575;
      5'd11: r = 31'd524287;
      5'd12: r = 31'd262143;
      5'd13: r = 31'd131071;
      5'd14: r = 31'd65535;
      5'd15: r = 31'd32767;
      5'd16: r = 31'd16383;
      5'd17: r = 31'd8191;
      5'd18: r = 31'd4095;
      5'd19: r = 31'd2047;
      5'd20: r = 31'd1024;
      5'd21: r = 31'd511;
      5'd22: r = 31'd255;
      5'd23: r = 31'd127;
      5'd24: r = 31'd63;
      5'd25: r = 31'd31;
      5'd26: r = 31'd15;
      5'd27: r = 31'd8;
      5'd28: r = 31'd4;
      5'd29: r = 31'd2;
      5'd30: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/dem_front.sv
`default_nettype none
module dem_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [2:0]        cfg_data_i,
  input  wire logic [31:0]       value_a_i,
  input  wire logic [31:0]       value_b_i,
  input  wire logic              final_pair_i,
  output dem_pkg::dem_item_t     item_o
);

  logic [2:0]  mode_q;
  logic [32:0] diff;
  logic [32:0] a_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dem_pkg::MODE_RMSE;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Magnitude of the difference and of the measured sample.
  always_comb begin
    diff  = {value_a_i[31], value_a_i} - {value_b_i[31], value_b_i};
    a_ext = {value_a_i[31], value_a_i};
    item_o.mode = (mode_q == dem_pkg::MODE_UNUSED) ? dem_pkg::MODE_ABS : mode_q;
    item_o.dif  = diff[32] ? 32'(-diff) : diff[31:0];
    item_o.mag  = a_ext[32] ? 32'(-a_ext) : a_ext[31:0];
    item_o.fin  = final_pair_i;
  end

endmodule
`default_nettype wire

>>> src/dem_queue.sv
`default_nettype none
module dem_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dem_pkg::dem_item_t push_data_i,
  input  wire logic              pop_i,
  output dem_pkg::dem_item_t     pop_data_o,
  output logic                   full_o,
  output logic                   empty_o
);

  dem_pkg::dem_item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = slot_q[rd_ptr_q];
  assign full_o     = (fill_q == 2'd2);
  assign empty_o    = (fill_q == 2'd0);

endmodule
`default_nettype wire

>>> src/dem_iter.sv
`default_nettype none
module dem_iter (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dem_pkg::dem_req_t req_i,
  output dem_pkg::dem_rsp_t      rsp_o
);

  logic         busy_q, done_q, op_q, over_q;
  logic [6:0]   cnt_q;
  logic [127:0] work_q;
  logic [63:0]  den_q, acc_q;
  logic [65:0]  rem_q;

  logic [64:0]  dsh;
  logic         dge;
  logic [67:0]  ssh, strial;
  logic         sge;
  logic         last;

  always_comb begin
    dsh    = {rem_q[63:0], work_q[127]};
    dge    = dsh >= {1'b0, den_q};
    ssh    = {rem_q, work_q[127:126]};
    strial = {2'b00, acc_q, 2'b01};
    sge    = ssh >= strial;
    last   = op_q ? (cnt_q == 7'd63) : (cnt_q == 7'd127);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= dem_pkg::OP_DIV;
      over_q <= 1'b0;
      cnt_q  <= '0;
      work_q <= '0;
      den_q  <= '0;
      acc_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        work_q <= req_i.num;
        den_q  <= req_i.den;
        acc_q  <= '0;
        rem_q  <= '0;
        over_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (op_q == dem_pkg::OP_SQRT) begin
          work_q <= {work_q[125:0], 2'b00};
          rem_q  <= sge ? 66'(ssh - strial) : ssh[65:0];
          acc_q  <= {acc_q[62:0], sge};
        end else begin
          work_q <= {work_q[126:0], 1'b0};
          rem_q  <= {2'b00, (dge ? 64'(dsh - {1'b0, den_q}) : dsh[63:0])};
          acc_q  <= {acc_q[62:0], dge};
          // Quotient bits at weight 2^63 and above saturate the result.
          if (dge && cnt_q <= 7'd64) begin
            over_q <= 1'b1;
          end
        end
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.over = over_q;
  assign rsp_o.res  = acc_q;

endmodule
`default_nettype wire

>>> src/dem_back.sv
`default_nettype none
module dem_back #(
  parameter int unsigned MAX_POINTS = dem_pkg::MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = dem_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire dem_pkg::dem_item_t item_i,
  output logic                    pop_o,
  output dem_pkg::dem_req_t       req_o,
  input  wire dem_pkg::dem_rsp_t  rsp_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [62:0]             error_value_o,
  output logic [2:0]              reported_type_o,
  output logic [16:0]             points_counted_o,
  output logic [15:0]             first_index_o,
  output logic [15:0]             last_index_o,
  output logic                    divide_fault_o
);

  localparam int POS_W = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLS   = 5'd1;
  localparam logic [4:0] S_SQD   = 5'd2;
  localparam logic [4:0] S_ADDD  = 5'd3;
  localparam logic [4:0] S_SQA   = 5'd4;
  localparam logic [4:0] S_ADDA  = 5'd5;
  localparam logic [4:0] S_NORM  = 5'd6;
  localparam logic [4:0] S_CORD  = 5'd7;
  localparam logic [4:0] S_ACC   = 5'd8;
  localparam logic [4:0] S_MDIV  = 5'd9;
  localparam logic [4:0] S_BOOK  = 5'd10;
  localparam logic [4:0] S_FIN   = 5'd11;
  localparam logic [4:0] S_REP   = 5'd12;
  localparam logic [4:0] S_RMDIV = 5'd13;
  localparam logic [4:0] S_RMSQ  = 5'd14;
  localparam logic [4:0] S_EUSQ  = 5'd15;
  localparam logic [4:0] S_FDIV  = 5'd16;
  localparam logic [4:0] S_EMIT  = 5'd17;

  logic [4:0]         state_q;
  dem_pkg::dem_item_t it_q;
  dem_pkg::dem_req_t  req_q;
  logic [63:0]        main_q, aux_q, sq_q, term_q, value_q;
  logic [POS_W-1:0]   counted_q, pos_q, last_q, first_q;
  logic               count_q, fault_q;
  logic [2:0]         type_q;
  logic signed [39:0] x_q, y_q, nx, ny;
  logic signed [33:0] z_q, nz;
  logic [4:0]         i_q;
  logic               out_valid_q;
  logic               take_out;
  logic               emit;
  logic               start_d;

  function automatic logic [63:0] sat_add(input logic [63:0] s, input logic [63:0] t);
    logic [64:0] r;
    r = {1'b0, s} + {1'b0, t};
    return r[64] ? '1 : r[63:0];
  endfunction

  function automatic logic [63:0] q30_to_frac(input logic signed [33:0] z);
    logic [63:0] zc;
    if (z < 0) begin
      zc = '0;
    end else if (z > $signed(dem_pkg::HALF_PI_Q30)) begin
      zc = 64'(dem_pkg::HALF_PI_Q30);
    end else begin
      zc = 64'(unsigned'(z));
    end
    return (zc + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  // One CORDIC rotation toward y = 0.
  always_comb begin
    if (y_q >= 0) begin
      nx = x_q + (y_q >>> i_q);
      ny = y_q - (x_q >>> i_q);
      nz = z_q + $signed({3'b000, dem_pkg::atan_tab(i_q)});
    end else begin
      nx = x_q - (y_q >>> i_q);
      ny = y_q + (x_q >>> i_q);
      nz = z_q - $signed({3'b000, dem_pkg::atan_tab(i_q)});
    end
  end

  // Start pulse for the shared divide/square-root unit.
  always_comb begin
    case (state_q)
      S_CLS: begin
        start_d = (pos_q < POS_W'(MAX_POINTS)) && (it_q.mode == dem_pkg::MODE_MAPE) &&
                  (it_q.mag != '0);
      end
      S_REP: begin
        case (it_q.mode)
          dem_pkg::MODE_RMSE, dem_pkg::MODE_RFAC,
          dem_pkg::MODE_MAPE, dem_pkg::MODE_MAAPE: start_d = (counted_q != '0);
          dem_pkg::MODE_PCT:  start_d = (aux_q != '0);
          dem_pkg::MODE_EUCL: start_d = 1'b1;
          default:            start_d = 1'b0;
        endcase
      end
      S_RMDIV: start_d = rsp_i.done;
      S_EUSQ:  start_d = rsp_i.done && (rsp_i.res != '0);
      default: start_d = 1'b0;
    endcase
  end

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign take_out = out_valid_q && !out_stall_i;
  assign emit     = (state_q == S_EMIT) && (!out_valid_q || take_out);
  assign req_o    = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      it_q        <= '0;
      req_q       <= '0;
      main_q      <= '0;
      aux_q       <= '0;
      sq_q        <= '0;
      term_q      <= '0;
      value_q     <= '0;
      counted_q   <= '0;
      pos_q       <= '0;
      last_q      <= '0;
      first_q     <= '0;
      count_q     <= 1'b0;
      fault_q     <= 1'b0;
      type_q      <= dem_pkg::MODE_RMSE;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
      error_value_o    <= '0;
      reported_type_o  <= '0;
      points_counted_o <= '0;
      first_index_o    <= '0;
      last_index_o     <= '0;
      divide_fault_o   <= 1'b0;
    end else begin
      req_q.start <= start_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (take_out) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            it_q    <= item_i;
            state_q <= S_CLS;
          end
        end
        S_CLS: begin
          // A zero sample is skipped under MAPE and does not count.
          count_q <= !((it_q.mode == dem_pkg::MODE_MAPE) && (it_q.mag == '0));
          if (pos_q >= POS_W'(MAX_POINTS)) begin
            state_q <= S_FIN;
          end else begin
            case (it_q.mode)
              dem_pkg::MODE_RMSE, dem_pkg::MODE_RFAC, dem_pkg::MODE_EUCL: begin
                state_q <= S_SQD;
              end
              dem_pkg::MODE_MAAPE: begin
                if (it_q.dif == '0) begin
                  term_q  <= '0;
                  state_q <= S_ACC;
                end else if (it_q.mag == '0) begin
                  term_q  <= q30_to_frac($signed(dem_pkg::HALF_PI_Q30));
                  state_q <= S_ACC;
                end else begin
                  x_q     <= $signed({8'd0, it_q.mag});
                  y_q     <= $signed({8'd0, it_q.dif});
                  state_q <= S_NORM;
                end
              end
              dem_pkg::MODE_MAPE: begin
                if (it_q.mag == '0) begin
                  state_q <= S_BOOK;
                end else begin
                  req_q.op    <= dem_pkg::OP_DIV;
                  req_q.num   <= 128'(it_q.dif) << FRAC_BITS;
                  req_q.den   <= 64'(it_q.mag);
                  state_q     <= S_MDIV;
                end
              end
              dem_pkg::MODE_PCT: begin
                main_q  <= sat_add(main_q, 64'(it_q.dif));
                aux_q   <= sat_add(aux_q, 64'(it_q.mag));
                state_q <= S_BOOK;
              end
              default: begin
                main_q  <= sat_add(main_q, 64'(it_q.dif));
                state_q <= S_BOOK;
              end
            endcase
          end
        end
        S_SQD: begin
          sq_q    <= 64'(it_q.dif) * 64'(it_q.dif);
          state_q <= S_ADDD;
        end
        S_ADDD: begin
          main_q  <= sat_add(main_q, sq_q >> FRAC_BITS);
          state_q <= (it_q.mode == dem_pkg::MODE_EUCL) ? S_SQA : S_BOOK;
        end
        S_SQA: begin
          sq_q    <= 64'(it_q.mag) * 64'(it_q.mag);
          state_q <= S_ADDA;
        end
        S_ADDA: begin
          aux_q   <= sat_add(aux_q, sq_q >> FRAC_BITS);
          state_q <= S_BOOK;
        end
        S_NORM: begin
          if (x_q[39:31] == '0 && y_q[39:31] == '0) begin
            x_q <= x_q <<< 1;
            y_q <= y_q <<< 1;
          end else begin
            z_q     <= '0;
            i_q     <= '0;
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          x_q <= nx;
          y_q <= ny;
          z_q <= nz;
          i_q <= i_q + 5'd1;
          if (i_q == 5'd31) begin
            term_q  <= q30_to_frac(nz);
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          main_q  <= sat_add(main_q, term_q);
          state_q <= S_BOOK;
        end
        S_MDIV: begin
          if (rsp_i.done) begin
            main_q  <= sat_add(main_q, rsp_i.res);
            state_q <= S_BOOK;
          end
        end
        S_BOOK: begin
          if (counted_q == '0) begin
            first_q <= pos_q;
          end
          if (count_q) begin
            last_q    <= pos_q;
            counted_q <= counted_q + POS_W'(1);
          end
          pos_q   <= pos_q + POS_W'(1);
          state_q <= S_FIN;
        end
        S_FIN: begin
          state_q <= it_q.fin ? S_REP : S_IDLE;
        end
        S_REP: begin
          req_q.op  <= (it_q.mode == dem_pkg::MODE_EUCL) ? dem_pkg::OP_SQRT : dem_pkg::OP_DIV;
          req_q.den <= (it_q.mode == dem_pkg::MODE_PCT) ? aux_q : 64'(counted_q);
          case (it_q.mode)
            dem_pkg::MODE_RMSE, dem_pkg::MODE_RFAC,
            dem_pkg::MODE_MAPE, dem_pkg::MODE_MAAPE: begin
              type_q  <= it_q.mode;
              value_q <= '0;
              fault_q <= (counted_q == '0);
              if (counted_q == '0) begin
                state_q <= S_EMIT;
              end else if (it_q.mode == dem_pkg::MODE_RMSE) begin
                req_q.num <= 128'(main_q);
                state_q   <= S_RMDIV;
              end else if (it_q.mode == dem_pkg::MODE_RFAC) begin
                req_q.num <= 128'(main_q);
                state_q   <= S_FDIV;
              end else begin
                req_q.num <= 128'(main_q) * 128'd100;
                state_q   <= S_FDIV;
              end
            end
            dem_pkg::MODE_PCT: begin
              fault_q <= 1'b0;
              if (aux_q == '0) begin
                type_q  <= dem_pkg::MODE_ABS;
                value_q <= main_q;
                state_q <= S_EMIT;
              end else begin
                type_q      <= dem_pkg::MODE_PCT;
                value_q     <= '0;
                req_q.num   <= (128'(main_q) * 128'd100) << FRAC_BITS;
                state_q     <= S_FDIV;
              end
            end
            dem_pkg::MODE_EUCL: begin
              type_q      <= dem_pkg::MODE_EUCL;
              fault_q     <= 1'b0;
              value_q     <= '0;
              req_q.num   <= 128'(aux_q) << FRAC_BITS;
              state_q     <= S_EUSQ;
            end
            default: begin
              type_q  <= it_q.mode;
              fault_q <= 1'b0;
              value_q <= main_q;
              state_q <= S_EMIT;
            end
          endcase
        end
        S_RMDIV: begin
          if (rsp_i.done) begin
            req_q.op    <= dem_pkg::OP_SQRT;
            req_q.num   <= 128'(rsp_i.res) << FRAC_BITS;
            state_q     <= S_RMSQ;
          end
        end
        S_RMSQ: begin
          if (rsp_i.done) begin
            value_q <= rsp_i.res;
            state_q <= S_EMIT;
          end
        end
        S_EUSQ: begin
          if (rsp_i.done) begin
            if (rsp_i.res == '0) begin
              fault_q <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              req_q.op    <= dem_pkg::OP_DIV;
              req_q.num   <= 128'(main_q) << FRAC_BITS;
              req_q.den   <= rsp_i.res;
              state_q     <= S_FDIV;
            end
          end
        end
        S_FDIV: begin
          if (rsp_i.done) begin
            value_q <= rsp_i.over ? dem_pkg::SAT63 : rsp_i.res;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            error_value_o    <= (value_q > dem_pkg::SAT63) ? dem_pkg::SAT63[62:0]
                                                           : value_q[62:0];
            reported_type_o  <= type_q;
            points_counted_o <= 17'(64'(counted_q));
            first_index_o    <= 16'(64'(first_q));
            last_index_o     <= 16'(64'(last_q));
            divide_fault_o   <= fault_q;
            main_q    <= '0;
            aux_q     <= '0;
            counted_q <= '0;
            pos_q     <= '0;
            last_q    <= '0;
            first_q   <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> src/dataset_error_metric.sv
`default_nettype none
// Dataset error metric. Pairs of Q16.16 samples (value_a_i, value_b_i) enter on the
// input channel, which takes a transaction when in_valid_i is high and in_stall_o
// is low. Each of the first MAX_POINTS pairs adds its error term to the running sums
// of the metric set in the mode register; the pair marked by final_pair_i also makes
// one report transaction on the output channel, taken when out_valid_o is high and
// out_stall_i is low, after which the sums start over.
// The mode register is written through cfg_valid_i/cfg_data_i; cfg_ready_o is
// always high. Write it only while no pair is in flight.
// A front stage classifies each pair into a two-entry queue; a back sequencer
// works off the queue one pair at a time. Per pair: absolute and percent terms take
// an add, squared terms a squaring and an add, and Euclidean terms square both the
// difference and the sample; the arctangent takes a normalize plus 32 CORDIC
// rotations, and percentage terms use the bit-serial divide/square-root unit, which
// is shared with the report.
// Reset clears the sums, the counters and the mode (root mean square error).
// While the receiver stalls the report is held steady; the queue keeps taking
// pairs until it fills, then in_stall_o rises.
module dataset_error_metric #(
  parameter int unsigned MAX_POINTS = dem_pkg::MAX_POINTS_DEF,
  parameter int unsigned FRAC_BITS  = dem_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_a_i,
  input  wire logic [31:0] value_b_i,
  input  wire logic        final_pair_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [62:0]      error_value_o,
  output logic [2:0]       reported_type_o,
  output logic [16:0]      points_counted_o,
  output logic [15:0]      first_index_o,
  output logic [15:0]      last_index_o,
  output logic             divide_fault_o
);

  dem_pkg::dem_item_t front_item, queue_item;
  dem_pkg::dem_req_t  req;
  dem_pkg::dem_rsp_t  rsp;
  logic               full, empty, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  dem_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .value_a_i    (value_a_i),
    .value_b_i    (value_b_i),
    .final_pair_i (final_pair_i),
    .item_o       (front_item)
  );

  dem_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (front_item),
    .pop_i       (pop),
    .pop_data_o  (queue_item),
    .full_o      (full),
    .empty_o     (empty)
  );

  dem_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  dem_back #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .item_i           (queue_item),
    .pop_o            (pop),
    .req_o            (req),
    .rsp_i            (rsp),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .error_value_o    (error_value_o),
    .reported_type_o  (reported_type_o),
    .points_counted_o (points_counted_o),
    .first_index_o    (first_index_o),
    .last_index_o     (last_index_o),
    .divide_fault_o   (divide_fault_o)
  );

endmodule
`default_nettype wire
